>>> rtl/scancode_set1_to_ascii_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scancode set 1 decoder
// Concurrent checks in simulation, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_TO_ASCII_DECODER_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define SCS1DEC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SCS1DEC_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define SCS1DEC_ASSERT(lbl, clk, rstn, prop)
`define SCS1DEC_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

>>> rtl/scs1dec_pkg.sv
// ----------------------------------------------------------------------------
// scs1dec_pkg
// Types, scancode constants and key tables of the scancode set 1 decoder.
// ----------------------------------------------------------------------------
package scs1dec_pkg;

  localparam int MidDepthDef = 2;
  localparam int OutDepthDef = 2;

  localparam int MapLen = 59;

  localparam logic [1:0] ADDR_PAGE_LINES = 2'd0;

  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_RELEASE    = 8'h80;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
  localparam logic [7:0] SC_CTRL       = 8'h1D;
  localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_PGUP       = 8'h49;
  localparam logic [7:0] SC_PGDN       = 8'h51;
  localparam logic [7:0] SC_HOME       = 8'h47;
  localparam logic [7:0] SC_END        = 8'h4F;
  localparam logic [7:0] SC_UP         = 8'h48;
  localparam logic [7:0] SC_DOWN       = 8'h50;
  localparam logic [7:0] SC_LEFT       = 8'h4B;
  localparam logic [7:0] SC_RIGHT      = 8'h4D;
  localparam logic [6:0] SC_F11        = 7'h57;
  localparam logic [6:0] SC_F12        = 7'h58;

  localparam logic [7:0] CH_ARROW_BASE = 8'h80;
  localparam logic [7:0] CH_F11        = 8'h84;
  localparam logic [7:0] CH_F12        = 8'h85;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

  localparam logic [1:0] SCROLL_NONE   = 2'd0;
  localparam logic [1:0] SCROLL_UP     = 2'd1;
  localparam logic [1:0] SCROLL_DOWN   = 2'd2;
  localparam logic [1:0] SCROLL_BOTTOM = 2'd3;

  localparam logic [13:0] HOME_LINES   = 14'd9999;
  localparam logic [7:0]  PAGE_LINES_RST = 8'd12;

  localparam logic [7:0] PLAIN_MAP [MapLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [7:0] SHIFTED_MAP [MapLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  typedef enum logic [2:0] {
    KIND_PAGE_UP,
    KIND_PAGE_DOWN,
    KIND_HOME,
    KIND_END,
    KIND_ARROW,
    KIND_FKEY,
    KIND_KEY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic       pressed;
    logic [6:0] code;
    logic       shift;
    logic       letter_shift;
  } cmd_t;

  typedef struct packed {
    logic        has_char;
    logic [7:0]  char_code;
    logic        has_event;
    logic        event_pressed;
    logic [7:0]  event_code;
    logic [1:0]  scroll_op;
    logic [13:0] scroll_lines;
  } result_t;

endpackage

>>> rtl/scs1dec_fifo.sv
// ----------------------------------------------------------------------------
// scs1dec_fifo
// Small flop-based queue with registered storage and occupancy count.
// ----------------------------------------------------------------------------
`include "scancode_set1_to_ascii_decoder_assert.svh"

module scs1dec_fifo #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push_acc;
  logic             pop_acc;

  assign full_o   = (count_q == CntW'(Depth));
  assign empty_o  = (count_q == '0);
  assign push_acc = push_i && !full_o;
  assign pop_acc  = pop_i && !empty_o;
  assign rdata_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_acc) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_acc) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_acc && !pop_acc) begin
      count_d = count_q + CntW'(1);
    end else if (pop_acc && !push_acc) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `SCS1DEC_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(Depth))
  `SCS1DEC_ASSERT(a_push_grows, clk_i, rst_ni,
    (push_acc && !pop_acc) |=> (count_q == $past(count_q) + CntW'(1)))
  `SCS1DEC_ASSERT(a_pop_shrinks, clk_i, rst_ni,
    (pop_acc && !push_acc) |=> (count_q == $past(count_q) - CntW'(1)))
  `SCS1DEC_ASSERT(a_head_holds, clk_i, rst_ni,
    (!empty_o && !pop_i) |=> $stable(rdata_o))

endmodule

>>> rtl/scs1dec_front.sv
// ----------------------------------------------------------------------------
// scs1dec_front
// Tracks shift, caps lock and extended prefix; classifies each scancode
// into a command for the back end, or drops it when it yields nothing.
// ----------------------------------------------------------------------------
module scs1dec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          scancode_i,
  output logic                cmd_valid_o,
  output scs1dec_pkg::cmd_t   cmd_o
);

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic prefix_q, prefix_d;

  always_comb begin
    shift_d      = shift_q;
    caps_d       = caps_q;
    prefix_d     = prefix_q;
    cmd_valid_o  = 1'b0;
    cmd_o.kind         = scs1dec_pkg::KIND_KEY;
    cmd_o.pressed      = ~scancode_i[7];
    cmd_o.code         = scancode_i[6:0];
    cmd_o.shift        = shift_q;
    cmd_o.letter_shift = shift_q ^ caps_q;
    if (valid_i) begin
      if (scancode_i == scs1dec_pkg::SC_PREFIX) begin
        prefix_d = 1'b1;
      end else if (prefix_q) begin
        prefix_d = 1'b0;
        if ((scancode_i & scs1dec_pkg::SC_RELEASE) == 8'h00) begin
          cmd_valid_o = 1'b1;
          case (scancode_i)
            scs1dec_pkg::SC_PGUP:  cmd_o.kind = scs1dec_pkg::KIND_PAGE_UP;
            scs1dec_pkg::SC_PGDN:  cmd_o.kind = scs1dec_pkg::KIND_PAGE_DOWN;
            scs1dec_pkg::SC_HOME:  cmd_o.kind = scs1dec_pkg::KIND_HOME;
            scs1dec_pkg::SC_END:   cmd_o.kind = scs1dec_pkg::KIND_END;
            scs1dec_pkg::SC_UP: begin
              cmd_o.kind = scs1dec_pkg::KIND_ARROW;
              cmd_o.code = 7'd0;
            end
            scs1dec_pkg::SC_DOWN: begin
              cmd_o.kind = scs1dec_pkg::KIND_ARROW;
              cmd_o.code = 7'd1;
            end
            scs1dec_pkg::SC_LEFT: begin
              cmd_o.kind = scs1dec_pkg::KIND_ARROW;
              cmd_o.code = 7'd2;
            end
            scs1dec_pkg::SC_RIGHT: begin
              cmd_o.kind = scs1dec_pkg::KIND_ARROW;
              cmd_o.code = 7'd3;
            end
            default: cmd_valid_o = 1'b0;
          endcase
        end
      end else begin
        case (scancode_i)
          scs1dec_pkg::SC_LSHIFT,
          scs1dec_pkg::SC_RSHIFT:     shift_d = 1'b1;
          scs1dec_pkg::SC_LSHIFT_REL,
          scs1dec_pkg::SC_RSHIFT_REL: shift_d = 1'b0;
          scs1dec_pkg::SC_CTRL,
          scs1dec_pkg::SC_CTRL_REL:   cmd_valid_o = 1'b0;
          scs1dec_pkg::SC_CAPS:       caps_d = ~caps_q;
          default: begin
            if (scancode_i[6:0] == scs1dec_pkg::SC_F11 ||
                scancode_i[6:0] == scs1dec_pkg::SC_F12) begin
              cmd_o.kind  = scs1dec_pkg::KIND_FKEY;
              cmd_valid_o = 1'b1;
            end else if (scancode_i[6:0] < 7'(scs1dec_pkg::MapLen)) begin
              cmd_valid_o = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

>>> rtl/scs1dec_back.sv
// ----------------------------------------------------------------------------
// scs1dec_back
// Turns a queued command into a result: key table lookup, event and
// scroll formatting. Drops keys that map to no character.
// ----------------------------------------------------------------------------
module scs1dec_back (
  input  logic                   cmd_valid_i,
  input  scs1dec_pkg::cmd_t      cmd_i,
  output logic                   cmd_pop_o,
  input  logic [7:0]             page_lines_i,
  input  logic                   res_full_i,
  output logic                   res_push_o,
  output scs1dec_pkg::result_t   res_o
);

  logic [5:0] idx;
  logic [7:0] plain_ch;
  logic [7:0] ch;
  logic       is_letter;
  logic       keep;

  assign idx       = cmd_i.code[5:0];
  assign plain_ch  = scs1dec_pkg::PLAIN_MAP[idx];
  assign is_letter = (plain_ch >= scs1dec_pkg::CH_LOWER_A) &&
                     (plain_ch <= scs1dec_pkg::CH_LOWER_Z);

  always_comb begin
    keep  = 1'b1;
    ch    = 8'h00;
    res_o = '0;
    case (cmd_i.kind)
      scs1dec_pkg::KIND_PAGE_UP: begin
        res_o.scroll_op    = scs1dec_pkg::SCROLL_UP;
        res_o.scroll_lines = {6'd0, page_lines_i};
      end
      scs1dec_pkg::KIND_PAGE_DOWN: begin
        res_o.scroll_op    = scs1dec_pkg::SCROLL_DOWN;
        res_o.scroll_lines = {6'd0, page_lines_i};
      end
      scs1dec_pkg::KIND_HOME: begin
        res_o.scroll_op    = scs1dec_pkg::SCROLL_UP;
        res_o.scroll_lines = scs1dec_pkg::HOME_LINES;
      end
      scs1dec_pkg::KIND_END: begin
        res_o.scroll_op = scs1dec_pkg::SCROLL_BOTTOM;
      end
      default: begin
        if (cmd_i.kind == scs1dec_pkg::KIND_ARROW) begin
          ch = scs1dec_pkg::CH_ARROW_BASE | {6'd0, cmd_i.code[1:0]};
        end else if (cmd_i.kind == scs1dec_pkg::KIND_FKEY) begin
          ch = (cmd_i.code == scs1dec_pkg::SC_F12) ? scs1dec_pkg::CH_F12
                                                   : scs1dec_pkg::CH_F11;
        end else if (is_letter ? cmd_i.letter_shift : cmd_i.shift) begin
          ch = scs1dec_pkg::SHIFTED_MAP[idx];
        end else begin
          ch = plain_ch;
        end
        keep                = (ch != 8'h00);
        res_o.has_event     = 1'b1;
        res_o.event_pressed = cmd_i.pressed;
        res_o.event_code    = ch;
        if (cmd_i.pressed) begin
          res_o.has_char  = 1'b1;
          res_o.char_code = ch;
          res_o.scroll_op = scs1dec_pkg::SCROLL_BOTTOM;
        end
      end
    endcase
  end

  assign cmd_pop_o  = cmd_valid_i && !res_full_i;
  assign res_push_o = cmd_pop_o && keep;

endmodule

>>> rtl/scancode_set1_to_ascii_decoder.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder
// Scancode set 1 to ASCII decoder with page-scroll configuration register.
//
//   port group          direction  handshake
//   scancode_i          in         push / full
//   result fields       out        empty / pop
//   page_scroll_lines   cfg        APB write at paddr 0
//
// One scancode is taken per cycle while full is low; its result reaches
// the result ports through both queues (front classifier into the command
// queue, back end into the result queue) and can then be popped.
// Reset clears shift, caps and prefix flags, empties both queues and loads
// 12 into page_scroll_lines. full rises only when the command queue backs
// up behind a stalled result queue.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_decoder #(
  parameter int MidDepth = scs1dec_pkg::MidDepthDef,
  parameter int OutDepth = scs1dec_pkg::OutDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  scancode_i,
  output logic        empty,
  input  logic        pop,
  output logic        has_char_o,
  output logic [7:0]  char_code_o,
  output logic        has_event_o,
  output logic        event_pressed_o,
  output logic [7:0]  event_code_o,
  output logic [1:0]  scroll_op_o,
  output logic [13:0] scroll_lines_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CmdW = $bits(scs1dec_pkg::cmd_t);
  localparam int ResW = $bits(scs1dec_pkg::result_t);

  logic                 page_wr;
  logic [7:0]           page_lines_q;
  logic                 front_valid;
  scs1dec_pkg::cmd_t    front_cmd;
  logic                 mid_full;
  logic                 mid_empty;
  logic [CmdW-1:0]      mid_rdata;
  scs1dec_pkg::cmd_t    mid_cmd;
  logic                 mid_pop;
  logic                 res_full;
  logic                 res_push;
  scs1dec_pkg::result_t res;
  logic [ResW-1:0]      out_rdata;
  scs1dec_pkg::result_t out_res;

  assign full    = mid_full;
  assign pready  = 1'b1;
  assign prdata  = (paddr == scs1dec_pkg::ADDR_PAGE_LINES) ? {24'd0, page_lines_q} : 32'd0;
  assign page_wr = psel && penable && pwrite && pready &&
                   (paddr == scs1dec_pkg::ADDR_PAGE_LINES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_lines_q <= scs1dec_pkg::PAGE_LINES_RST;
    end else if (page_wr) begin
      page_lines_q <= pwdata[7:0];
    end
  end

  scs1dec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (push && !mid_full),
    .scancode_i  (scancode_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  scs1dec_fifo #(
    .Width (CmdW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_cmd),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_cmd = scs1dec_pkg::cmd_t'(mid_rdata);

  scs1dec_back u_back (
    .cmd_valid_i  (!mid_empty),
    .cmd_i        (mid_cmd),
    .cmd_pop_o    (mid_pop),
    .page_lines_i (page_lines_q),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  scs1dec_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_res         = scs1dec_pkg::result_t'(out_rdata);
  assign has_char_o      = out_res.has_char;
  assign char_code_o     = out_res.char_code;
  assign has_event_o     = out_res.has_event;
  assign event_pressed_o = out_res.event_pressed;
  assign event_code_o    = out_res.event_code;
  assign scroll_op_o     = out_res.scroll_op;
  assign scroll_lines_o  = out_res.scroll_lines;

endmodule

>>> test/scancode_set1_to_ascii_decoder_tb.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder_tb
// Drives scancode bytes through the push/full port and checks every result
// popped from the decoder against an in-bench decoder of scancode set 1,
// with random gaps on both sides and several page scroll settings
// written and read back over the APB port between runs.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT       = 17;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAP_ENTRIES    = 59;

  localparam logic [7:0] KEY_PLAIN [MAP_ENTRIES] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [7:0] KEY_SHIFTED [MAP_ENTRIES] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
  };

  localparam logic [7:0] EXT_KEYS [8] = '{
    scs1dec_pkg::SC_PGUP, scs1dec_pkg::SC_PGDN, scs1dec_pkg::SC_HOME,
    scs1dec_pkg::SC_END, scs1dec_pkg::SC_UP, scs1dec_pkg::SC_DOWN,
    scs1dec_pkg::SC_LEFT, scs1dec_pkg::SC_RIGHT
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  scancode_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        has_char_o;
  logic [7:0]  char_code_o;
  logic        has_event_o;
  logic        event_pressed_o;
  logic [7:0]  event_code_o;
  logic [1:0]  scroll_op_o;
  logic [13:0] scroll_lines_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]           scancode_q [$];
  scs1dec_pkg::result_t decoded_q [$];

  bit         sender_hold = 1'b1;
  bit         no_idle = 1'b0;
  int         issued = 0;
  int         accepted = 0;
  int         quiet_cycles = 0;
  int         mismatches = 0;

  logic [7:0] page_lines = scs1dec_pkg::PAGE_LINES_RST;
  bit         shift_active = 1'b0;
  bit         caps_active = 1'b0;
  bit         ctrl_active = 1'b0;
  bit         ext_pending = 1'b0;

  scancode_set1_to_ascii_decoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .scancode_i      (scancode_i),
    .empty           (empty),
    .pop             (pop),
    .has_char_o      (has_char_o),
    .char_code_o     (char_code_o),
    .has_event_o     (has_event_o),
    .event_pressed_o (event_pressed_o),
    .event_code_o    (event_code_o),
    .scroll_op_o     (scroll_op_o),
    .scroll_lines_o  (scroll_lines_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic scs1dec_pkg::result_t key_press(input logic [7:0] ch);
    scs1dec_pkg::result_t r;
    r = '0;
    r.has_char      = 1'b1;
    r.char_code     = ch;
    r.has_event     = 1'b1;
    r.event_pressed = 1'b1;
    r.event_code    = ch;
    r.scroll_op     = scs1dec_pkg::SCROLL_BOTTOM;
    return r;
  endfunction

  function automatic bit decode_scancode(input logic [7:0] sc,
                                         output scs1dec_pkg::result_t r);
    logic [6:0] code;
    logic [7:0] ch;
    bit         pressed;
    r = '0;
    if (sc == scs1dec_pkg::SC_PREFIX) begin
      ext_pending = 1'b1;
      return 1'b0;
    end
    if (ext_pending) begin
      ext_pending = 1'b0;
      if (sc[7]) return 1'b0;
      case (sc)
        scs1dec_pkg::SC_PGUP: begin
          r.scroll_op    = scs1dec_pkg::SCROLL_UP;
          r.scroll_lines = {6'd0, page_lines};
        end
        scs1dec_pkg::SC_PGDN: begin
          r.scroll_op    = scs1dec_pkg::SCROLL_DOWN;
          r.scroll_lines = {6'd0, page_lines};
        end
        scs1dec_pkg::SC_HOME: begin
          r.scroll_op    = scs1dec_pkg::SCROLL_UP;
          r.scroll_lines = scs1dec_pkg::HOME_LINES;
        end
        scs1dec_pkg::SC_END:   r.scroll_op = scs1dec_pkg::SCROLL_BOTTOM;
        scs1dec_pkg::SC_UP:    r = key_press(scs1dec_pkg::CH_ARROW_BASE);
        scs1dec_pkg::SC_DOWN:  r = key_press(scs1dec_pkg::CH_ARROW_BASE + 8'd1);
        scs1dec_pkg::SC_LEFT:  r = key_press(scs1dec_pkg::CH_ARROW_BASE + 8'd2);
        scs1dec_pkg::SC_RIGHT: r = key_press(scs1dec_pkg::CH_ARROW_BASE + 8'd3);
        default:  return 1'b0;
      endcase
      return 1'b1;
    end
    if (sc == scs1dec_pkg::SC_LSHIFT || sc == scs1dec_pkg::SC_RSHIFT) begin
      shift_active = 1'b1;
      return 1'b0;
    end
    if (sc == scs1dec_pkg::SC_LSHIFT_REL || sc == scs1dec_pkg::SC_RSHIFT_REL) begin
      shift_active = 1'b0;
      return 1'b0;
    end
    if (sc == scs1dec_pkg::SC_CTRL) begin
      ctrl_active = 1'b1;
      return 1'b0;
    end
    if (sc == scs1dec_pkg::SC_CTRL_REL) begin
      ctrl_active = 1'b0;
      return 1'b0;
    end
    if (sc == scs1dec_pkg::SC_CAPS) begin
      caps_active = !caps_active;
      return 1'b0;
    end
    code    = sc[6:0];
    pressed = !sc[7];
    if (code == scs1dec_pkg::SC_F12 || code == scs1dec_pkg::SC_F11) begin
      ch = (code == scs1dec_pkg::SC_F12) ? scs1dec_pkg::CH_F12 : scs1dec_pkg::CH_F11;
    end else begin
      if (code >= MAP_ENTRIES) return 1'b0;
      ch = KEY_PLAIN[code[5:0]];
      if (ch >= scs1dec_pkg::CH_LOWER_A && ch <= scs1dec_pkg::CH_LOWER_Z) begin
        if (shift_active != caps_active) ch = KEY_SHIFTED[code[5:0]];
      end else if (shift_active) begin
        ch = KEY_SHIFTED[code[5:0]];
      end
      if (ch == 8'h00) return 1'b0;
    end
    if (pressed) begin
      r = key_press(ch);
    end else begin
      r.has_event  = 1'b1;
      r.event_code = ch;
    end
    return 1'b1;
  endfunction

  function automatic bit stall_now();
    return !no_idle && ($urandom_range(99) < IDLE_PCT);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (push && issued != accepted) begin
    end else if (scancode_q.size() != 0 && !sender_hold && !stall_now()) begin
      push       <= 1'b1;
      scancode_i <= scancode_q.pop_front();
      issued++;
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && !stall_now();
  end

  always @(posedge clk_i) begin : monitor
    scs1dec_pkg::result_t got;
    scs1dec_pkg::result_t want;
    scs1dec_pkg::result_t fresh;
    if (rst_ni) begin
      quiet_cycles++;
      if (push && !full) begin
        accepted++;
        quiet_cycles = 0;
        if (decode_scancode(scancode_i, fresh)) decoded_q.push_back(fresh);
      end
      if (pop && !empty) begin
        quiet_cycles = 0;
        got = '{has_char_o, char_code_o, has_event_o, event_pressed_o,
                event_code_o, scroll_op_o, scroll_lines_o};
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'(got));
        end else begin
          want = decoded_q.pop_front();
          if (got.has_char !== want.has_char)
            report_mismatch("has_char", 64'(want.has_char), 64'(got.has_char));
          if (got.char_code !== want.char_code)
            report_mismatch("char_code", 64'(want.char_code), 64'(got.char_code));
          if (got.has_event !== want.has_event)
            report_mismatch("has_event", 64'(want.has_event), 64'(got.has_event));
          if (got.event_pressed !== want.event_pressed)
            report_mismatch("event_pressed", 64'(want.event_pressed),
                            64'(got.event_pressed));
          if (got.event_code !== want.event_code)
            report_mismatch("event_code", 64'(want.event_code), 64'(got.event_code));
          if (got.scroll_op !== want.scroll_op)
            report_mismatch("scroll_op", 64'(want.scroll_op), 64'(got.scroll_op));
          if (got.scroll_lines !== want.scroll_lines)
            report_mismatch("scroll_lines", 64'(want.scroll_lines),
                            64'(got.scroll_lines));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    while (scancode_q.size() != 0 || issued != accepted || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_page_lines(input logic [7:0] lines);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= scs1dec_pkg::ADDR_PAGE_LINES;
    pwdata  <= {24'd0, lines};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    page_lines = lines;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {24'd0, lines})
      report_mismatch("page_scroll_lines readback", 64'(lines), 64'(rd));
  endtask

  task automatic queue_random_phase(input int n_items);
    logic [7:0] key;
    logic [7:0] tap;
    while (scancode_q.size() < n_items) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          key = 8'($urandom_range(8'h58, 1));
          scancode_q.push_back(key);
          if ($urandom_range(3) == 0) scancode_q.push_back(8'($urandom_range(8'h58, 1)));
          scancode_q.push_back(key | scs1dec_pkg::SC_RELEASE);
        end
        3: begin
          key = $urandom_range(1) ? scs1dec_pkg::SC_LSHIFT : scs1dec_pkg::SC_RSHIFT;
          scancode_q.push_back(key);
          repeat ($urandom_range(3, 1)) begin
            tap = 8'($urandom_range(8'h58, 1));
            scancode_q.push_back(tap);
            scancode_q.push_back(tap | scs1dec_pkg::SC_RELEASE);
          end
          scancode_q.push_back(key | scs1dec_pkg::SC_RELEASE);
        end
        4: begin
          scancode_q.push_back(scs1dec_pkg::SC_CAPS);
          if ($urandom_range(1))
            scancode_q.push_back(scs1dec_pkg::SC_CAPS | scs1dec_pkg::SC_RELEASE);
        end
        5, 6: begin
          scancode_q.push_back(scs1dec_pkg::SC_PREFIX);
          if ($urandom_range(7) == 0) scancode_q.push_back(scs1dec_pkg::SC_PREFIX);
          if ($urandom_range(7) == 0) key = 8'($urandom_range(8'h7F));
          else key = EXT_KEYS[3'($urandom_range(7))];
          scancode_q.push_back(key);
          if ($urandom_range(1)) begin
            scancode_q.push_back(scs1dec_pkg::SC_PREFIX);
            scancode_q.push_back(key | scs1dec_pkg::SC_RELEASE);
          end
        end
        7: begin
          scancode_q.push_back(scs1dec_pkg::SC_CTRL);
          scancode_q.push_back(8'($urandom_range(8'h58, 1)));
          scancode_q.push_back(scs1dec_pkg::SC_CTRL_REL);
        end
        8: begin
          key = {1'b0, ($urandom_range(1) ? scs1dec_pkg::SC_F12 : scs1dec_pkg::SC_F11)};
          scancode_q.push_back(key);
          scancode_q.push_back(key | scs1dec_pkg::SC_RELEASE);
        end
        default: scancode_q.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    logic [7:0] lines;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    scancode_q = '{
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_PGUP,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_PGDN,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_HOME,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_END,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_UP,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_DOWN,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_LEFT,
      scs1dec_pkg::SC_PREFIX, scs1dec_pkg::SC_RIGHT | scs1dec_pkg::SC_RELEASE,
      scs1dec_pkg::SC_LSHIFT, 8'h02, scs1dec_pkg::SC_LSHIFT_REL,
      scs1dec_pkg::SC_CAPS, 8'h1E, scs1dec_pkg::SC_CAPS,
      {1'b0, scs1dec_pkg::SC_F11}, {1'b1, scs1dec_pkg::SC_F12},
      8'h00, 8'hFF
    };
    sender_hold = 1'b0;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       lines = 8'd0;
        1:       lines = 8'hFF;
        default: lines = 8'($urandom_range(255));
      endcase
      sender_hold = 1'b1;
      set_page_lines(lines);
      no_idle = (phase == 1);
      queue_random_phase(400);
      sender_hold = 1'b0;
      drain();
    end

    if (decoded_q.size() != 0) begin
      $display("%0d expected results never produced", decoded_q.size());
    end
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
